>>> hw/rtl/cdt_pkg.sv
// ----------------------------------------------------------------------------
// cdt_pkg
// Shared types and constants for the countdown timer slot bank.
// ----------------------------------------------------------------------------
package cdt_pkg;

  // Operation codes of a request
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_REG   = 2'd1;
  localparam logic [1:0] OP_UNREG = 2'd2;

  localparam int OP_W     = 2;
  localparam int START_W  = 32;  // start_count port width
  localparam int SLOT_W   = 3;   // slot index port width, covers up to 8 slots
  localparam int MASK_W   = 5;   // fired mask width

  localparam int DEF_NUM_SLOTS   = 5;
  localparam int DEF_COUNT_WIDTH = 32;

  // Occupancy update, one slot per cycle
  typedef struct packed {
    logic              set;   // slot becomes busy
    logic              clr;   // slot becomes free
    logic [SLOT_W-1:0] idx;
  } occ_upd_t;

  // Occupancy status
  typedef struct packed {
    logic              free_any;
    logic [SLOT_W-1:0] free_idx;  // lowest free slot
  } occ_sts_t;

endpackage

>>> hw/rtl/cdt_ram.sv
// ----------------------------------------------------------------------------
// cdt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 5,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/cdt_occ.sv
// ----------------------------------------------------------------------------
// cdt_occ
// Per-slot busy bits and lowest-free-slot search.
// ----------------------------------------------------------------------------
module cdt_occ import cdt_pkg::*; #(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  occ_upd_t             upd_i,
  output occ_sts_t             sts_o,
  output logic [NUM_SLOTS-1:0] busy_slots_o
);

  logic [NUM_SLOTS-1:0] nz_q, nz_d;

  always_comb begin
    nz_d = nz_q;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (upd_i.idx == SLOT_W'(i)) begin
        if (upd_i.set) nz_d[i] = 1'b1;
        if (upd_i.clr) nz_d[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_q <= '0;
    end else begin
      nz_q <= nz_d;
    end
  end

  // Priority search, lowest index wins
  always_comb begin
    sts_o.free_any = ~&nz_q;
    sts_o.free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!nz_q[i]) sts_o.free_idx = SLOT_W'(i);
    end
  end

  assign busy_slots_o = nz_q;

endmodule

>>> hw/rtl/countdown_timer_slot_bank.sv
// ----------------------------------------------------------------------------
// countdown_timer_slot_bank
// Bank of down-counting timer slots with register, unregister and tick.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. For register and
// unregister the result strobe (done_o) rises in the next cycle and busy
// stays low. A tick walks all NUM_SLOTS slots through the count RAM, one
// read per cycle with the write-back in the cycle after each read, so busy
// is high for the whole walk and done_o pulses in the cycle busy falls.
// Every request gives exactly one result, shown for one cycle only; the
// receiver cannot stall it, and a new request may be accepted in the same
// cycle a result is shown. Result ports read zero when done_o is low. No
// clearing pass is needed after reset: per-slot busy bits mark which RAM
// entries hold a live count.
// ----------------------------------------------------------------------------
module countdown_timer_slot_bank import cdt_pkg::*; #(
  parameter int NUM_SLOTS   = DEF_NUM_SLOTS,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    op_i,
  input  logic [START_W-1:0] start_count_i,
  input  logic [SLOT_W-1:0]  slot_index_i,
  output logic               done_o,
  output logic [SLOT_W-1:0]  granted_slot_o,
  output logic               no_free_slot_o,
  output logic [MASK_W-1:0]  fired_mask_o
);

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CntW = $clog2(NUM_SLOTS + 1);  // holds NUM_SLOTS itself

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_TICK = 1'b1;

  logic state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;          // next slot to read
  logic rsp_v_q;                          // read data valid this cycle
  logic [IdxW-1:0] rsp_idx_q;             // slot of that read data
  logic [MASK_W-1:0] acc_q, acc_d;        // fired bits gathered so far

  logic done_q, done_d;
  logic [SLOT_W-1:0] granted_q, granted_d;
  logic nofree_q, nofree_d;
  logic [MASK_W-1:0] fired_q, fired_d;

  logic accept;
  logic [COUNT_WIDTH-1:0] new_count;
  logic rd_issue;
  logic hit, fire, last;

  occ_upd_t occ_upd;
  occ_sts_t occ_sts;
  logic [NUM_SLOTS-1:0] busy_slots;

  logic ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

  assign accept    = start && !busy;
  assign new_count = COUNT_WIDTH'(start_count_i);

  // Tick walk: read slot idx_q now, act on its data next cycle
  assign rd_issue = (state_q == ST_TICK) && (idx_q < CntW'(NUM_SLOTS));
  assign hit      = rsp_v_q && busy_slots[rsp_idx_q];
  assign fire     = hit && (ram_rdata == COUNT_WIDTH'(1));
  assign last     = rsp_v_q && (rsp_idx_q == IdxW'(NUM_SLOTS - 1));

  // Slot busy bits
  always_comb begin
    occ_upd = '0;
    if (accept && op_i == OP_REG) begin
      occ_upd.set = occ_sts.free_any && (new_count != '0);
      occ_upd.idx = occ_sts.free_idx;
    end else if (accept && op_i == OP_UNREG) begin
      occ_upd.clr = (32'(slot_index_i) < NUM_SLOTS);
      occ_upd.idx = slot_index_i;
    end else if (fire) begin
      occ_upd.clr = 1'b1;                 // reached zero, slot freed
      occ_upd.idx = SLOT_W'(rsp_idx_q);
    end
  end

  cdt_occ #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_occ (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (occ_upd),
    .sts_o       (occ_sts),
    .busy_slots_o(busy_slots)
  );

  // Count RAM: register writes when idle, decrement write-back during walk.
  // Walk reads and writes never hit the same entry in one cycle.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rsp_idx_q;
    ram_wdata = ram_rdata - COUNT_WIDTH'(1);
    if (occ_upd.set) begin
      ram_we    = 1'b1;
      ram_waddr = IdxW'(occ_sts.free_idx);
      ram_wdata = new_count;
    end else if (hit && !fire) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re    = rd_issue;
  assign ram_raddr = idx_q[IdxW-1:0];

  cdt_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(NUM_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Sequencer and result register
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    acc_d     = acc_q;
    done_d    = 1'b0;
    granted_d = '0;
    nofree_d  = 1'b0;
    fired_d   = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_TICK: begin
              state_d = ST_TICK;
              idx_d   = '0;
              acc_d   = '0;
            end
            OP_REG: begin
              done_d    = 1'b1;
              granted_d = occ_sts.free_any ? occ_sts.free_idx : '0;
              nofree_d  = !occ_sts.free_any;
            end
            default: begin
              done_d = 1'b1;              // unregister or unused code
            end
          endcase
        end
      end
      ST_TICK: begin
        if (rd_issue) idx_d = idx_q + CntW'(1);
        // slots above the mask width still count down, but do not report
        for (int b = 0; b < MASK_W; b++) begin
          if (fire && 32'(rsp_idx_q) == b) acc_d[b] = 1'b1;
        end
        if (last) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
          fired_d = acc_d;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      rsp_v_q   <= 1'b0;
      done_q    <= 1'b0;
      granted_q <= '0;
      nofree_q  <= 1'b0;
      fired_q   <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      rsp_v_q   <= rd_issue;
      done_q    <= done_d;
      granted_q <= granted_d;
      nofree_q  <= nofree_d;
      fired_q   <= fired_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_idx_q <= idx_q[IdxW-1:0];
    acc_q     <= acc_d;
  end

  assign busy           = (state_q == ST_TICK);
  assign done_o         = done_q;
  assign granted_slot_o = granted_q;
  assign no_free_slot_o = nofree_q;
  assign fired_mask_o   = fired_q;

endmodule

>>> hw/rtl/cdt_checker.sv
// ----------------------------------------------------------------------------
// cdt_checker
// Port-level checks for the countdown timer slot bank, bound to the top.
// ----------------------------------------------------------------------------
module cdt_checker import cdt_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [OP_W-1:0]    op_i,
  input logic               done_o,
  input logic [SLOT_W-1:0]  granted_slot_o,
  input logic               no_free_slot_o,
  input logic [MASK_W-1:0]  fired_mask_o
);

  // Register/unregister answer in the next cycle without going busy
  a_short_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && op_i != OP_TICK |=> done_o && !busy && fired_mask_o == '0)
    else $error("short request did not complete in one cycle");

  // A tick makes the block busy
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && op_i == OP_TICK |=> busy && !done_o)
    else $error("tick did not start a walk");

  // Tick result comes out as busy falls
  a_tick_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o && granted_slot_o == '0 && !no_free_slot_o)
    else $error("tick end without a tick result");

  // Result ports are quiet outside the strobe
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> granted_slot_o == '0 && !no_free_slot_o && fired_mask_o == '0)
    else $error("result ports active without strobe");

  // Full bank reports slot zero
  a_nofree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && no_free_slot_o |-> granted_slot_o == '0)
    else $error("no free slot with nonzero grant");

endmodule

bind countdown_timer_slot_bank cdt_checker u_cdt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .op_i          (op_i),
  .done_o        (done_o),
  .granted_slot_o(granted_slot_o),
  .no_free_slot_o(no_free_slot_o),
  .fired_mask_o  (fired_mask_o)
);
